FILE: rtl/bb3_pkg.sv
package bb3_pkg;

    // pixel and channel geometry
    localparam int CHAN_W  = 8;
    localparam int CHANS   = 3;
    localparam int PIX_W   = CHAN_W * CHANS;
    localparam int SUM_W   = CHAN_W + 4;

    // configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd800;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd600;

    // frame size limits
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int MIN_SIZE      = 3;
    localparam int HGT_W         = $clog2(MAX_HEIGHT + 1);

    // floor(s / 9) = (s * 7282) >> 16 for any sum of nine 8-bit values
    localparam int RECIP_W    = 13;
    localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
    localparam int DIV9_SHIFT = 16;

endpackage

FILE: rtl/box_blur_3x3_stream.sv
// channel  | dir | handshake          | payload
// s_*      | in  | s_tvalid/s_tready  | s_tdata: red, green, blue; s_tuser: frame_start, flush
// m_*      | out | m_tvalid/m_tready  | m_tdata: red, green, blue; m_tlast: frame_end
// cfg_*    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (frame_width, frame_height)
//
// one pixel per clock while not stalled; a pixel goes through a three-stage pipeline built
// around a single line memory (read in stage 0, data and write-back in stage 1,
// divide in stage 2), then a result waits in the output register that drives m_tvalid.
// each result belongs to the pixel one line plus one pixel earlier in the stream.
// after reset the line memory holds no defined data and needs no clearing pass.
// s_tready drops only while the output register is full, not taken, and stage 2
// holds the next result; cfg_ready is always high.
module box_blur_3x3_stream #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] red_in, [15:8] green_in, [23:16] blue_in
    input  logic [bb3_pkg::PIX_W-1:0]      s_tdata,
    // [0] frame_start, [1] flush
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] red_out, [15:8] green_out, [23:16] blue_out
    output logic [bb3_pkg::PIX_W-1:0]      m_tdata,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]      cfg_data
);

    localparam int PW    = bb3_pkg::PIX_W;
    localparam int CHW   = bb3_pkg::CHAN_W;
    localparam int NCH   = bb3_pkg::CHANS;
    localparam int SMW   = bb3_pkg::SUM_W;
    localparam int CFW   = bb3_pkg::CFG_W;
    localparam int HW    = bb3_pkg::HGT_W;
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int SW    = CW + HW;
    localparam int RW    = SW + 1;
    localparam int CMPW  = (CW > CFW) ? CW : CFW;
    localparam int PRW   = SMW + bb3_pkg::RECIP_W;
    localparam int WORDW = 2 * PW;

    // configuration registers
    logic [CFW-1:0] fw_reg;
    logic [CFW-1:0] fh_reg;

    // position and output count
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [SW-1:0] cnt_reg, cnt_next;

    // stage 1
    logic            s1_valid_reg;
    logic            s1_emit_reg;
    logic            s1_int_reg;
    logic            s1_last_reg;
    logic            s1_fwd_reg;
    logic [AW-1:0]   s1_addr_reg;
    logic [PW-1:0]   s1_pix_reg;
    logic [WORDW-1:0] s1_fwd_data_reg;

    // stage 2
    logic            s2_valid_reg;
    logic            s2_int_reg;
    logic            s2_last_reg;
    logic [SMW-1:0]  s2_sum_reg [NCH];
    logic [PW-1:0]   s2_center_reg;

    // output register
    logic            out_valid_reg;
    logic            out_last_reg;
    logic [PW-1:0]   out_data_reg;

    // line memory: upper row in the high half, middle row in the low half
    logic [WORDW-1:0] line_mem [MAX_WIDTH];
    logic [WORDW-1:0] rd_data_reg;

    // column window: entries 0..2 newest column, 3..5 the one before
    logic [PW-1:0] win_reg [6];

    // stage 0 signals
    logic            en;
    logic            accept;
    logic            take;
    logic            frame_start;
    logic            flush;
    logic [CMPW-1:0] fw_x;
    logic [CW-1:0]   w_eff;
    logic [HW-1:0]   h_eff;
    logic [SW-1:0]   total;
    logic [CW-1:0]   col_cur;
    logic [RW-1:0]   row_cur;
    logic [SW-1:0]   cnt_cur;
    logic            col_nz;
    logic            emit0;
    logic            int0;
    logic            last0;
    logic            wrap0;
    logic [AW-1:0]   rd_addr;
    logic [PW-1:0]   pix0;

    // stage 1 and 2 signals
    logic            wr_en;
    logic [WORDW-1:0] mem_word;
    logic [PW-1:0]   up1;
    logic [PW-1:0]   mid1;
    logic [SMW-1:0]  sum1 [NCH];
    logic [PRW-1:0]  prod2 [NCH];
    logic [PW-1:0]   res2;

    // flow control
    assign en       = !(out_valid_reg && !m_tready && s2_valid_reg);
    assign s_tready = en;
    assign accept   = s_tvalid && en;
    assign cfg_ready = 1'b1;

    assign frame_start = s_tuser[0];
    assign flush       = s_tuser[1];

    // clamped frame size
    assign fw_x = CMPW'(fw_reg);
    always_comb
    begin
        if (fw_reg < CFW'(bb3_pkg::MIN_SIZE))
            w_eff = CW'(bb3_pkg::MIN_SIZE);
        else if (fw_x > CMPW'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(fw_x);
        if (fh_reg < CFW'(bb3_pkg::MIN_SIZE))
            h_eff = HW'(bb3_pkg::MIN_SIZE);
        else if (fh_reg > CFW'(bb3_pkg::MAX_HEIGHT))
            h_eff = HW'(bb3_pkg::MAX_HEIGHT);
        else
            h_eff = HW'(fh_reg);
    end

    assign total = SW'(w_eff) * SW'(h_eff);

    // stage 0: position, emit and border decisions
    assign col_cur = frame_start ? '0 : col_reg;
    assign row_cur = frame_start ? '0 : row_reg;
    assign cnt_cur = frame_start ? '0 : cnt_reg;
    assign take    = accept && (cnt_cur < total);
    assign col_nz  = (col_cur != '0);
    assign emit0   = col_nz ? (row_cur >= RW'(1)) : (row_cur >= RW'(2));
    assign int0    = col_nz && (row_cur >= RW'(2)) && (row_cur < RW'(h_eff))
                     && (col_cur >= CW'(2)) && (col_cur < w_eff);
    assign last0   = ((cnt_cur + SW'(1)) == total);
    assign wrap0   = (({1'b0, col_cur} + (CW+1)'(1)) >= {1'b0, w_eff});
    assign rd_addr = col_cur[AW-1:0];
    assign pix0    = flush ? '0 : s_tdata;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        cnt_next = cnt_reg;
        if (take)
        begin
            if (wrap0)
            begin
                col_next = '0;
                row_next = row_cur + RW'(1);
            end
            else
            begin
                col_next = col_cur + CW'(1);
                row_next = row_cur;
            end
            cnt_next = emit0 ? (cnt_cur + SW'(1)) : cnt_cur;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= bb3_pkg::FRAME_WIDTH_RST;
            fh_reg <= bb3_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bb3_pkg::REG_FRAME_WIDTH:  fw_reg <= cfg_data;
                bb3_pkg::REG_FRAME_HEIGHT: fh_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: memory data with forwarding, window and sums
    assign wr_en    = en && s1_valid_reg;
    assign mem_word = s1_fwd_reg ? s1_fwd_data_reg : rd_data_reg;
    assign up1      = mem_word[WORDW-1:PW];
    assign mid1     = mem_word[PW-1:0];

    always_comb
    begin
        for (int k = 0; k < NCH; k++)
        begin
            sum1[k] = SMW'(up1[k*CHW +: CHW]) + SMW'(mid1[k*CHW +: CHW])
                      + SMW'(s1_pix_reg[k*CHW +: CHW]);
            for (int j = 0; j < 6; j++)
                sum1[k] = sum1[k] + SMW'(win_reg[j][k*CHW +: CHW]);
        end
    end

    // line memory, one write and one read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[s1_addr_reg] <= {mid1, s1_pix_reg};
        if (accept)
            rd_data_reg <= line_mem[rd_addr];
    end

    // stage 2: divide by nine or pass the center through
    always_comb
    begin
        for (int k = 0; k < NCH; k++)
        begin
            prod2[k] = PRW'(s2_sum_reg[k]) * PRW'(bb3_pkg::DIV9_RECIP);
            res2[k*CHW +: CHW] = s2_int_reg ? prod2[k][bb3_pkg::DIV9_SHIFT +: CHW]
                                            : s2_center_reg[k*CHW +: CHW];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < 6; j++)
                win_reg[j] <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            cnt_reg <= cnt_next;
            if (en)
            begin
                s1_valid_reg <= take;
                s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            end
            if (wr_en)
            begin
                win_reg[3] <= win_reg[0];
                win_reg[4] <= win_reg[1];
                win_reg[5] <= win_reg[2];
                win_reg[0] <= up1;
                win_reg[1] <= mid1;
                win_reg[2] <= s1_pix_reg;
            end
            if (en && s2_valid_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_emit_reg     <= emit0;
            s1_int_reg      <= int0;
            s1_last_reg     <= last0;
            s1_addr_reg     <= rd_addr;
            s1_pix_reg      <= pix0;
            s1_fwd_reg      <= wr_en && (s1_addr_reg == rd_addr);
            s1_fwd_data_reg <= {mid1, s1_pix_reg};
            s2_int_reg      <= s1_int_reg;
            s2_last_reg     <= s1_last_reg;
            s2_center_reg   <= win_reg[1];
            for (int k = 0; k < NCH; k++)
                s2_sum_reg[k] <= sum1[k];
        end
        if (en && s2_valid_reg)
        begin
            out_data_reg <= res2;
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_W          = bb3_pkg::MAX_WIDTH_DEF;
    localparam int MAX_H          = bb3_pkg::MAX_HEIGHT;
    localparam int LATENCY_WAIT   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_PIXELS   = 250;
    localparam int DIR_ROWS       = 19;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } pix_result_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        frame_start;
        logic        flush;
        logic        checked;
        pix_result_t want;
    } dir_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [bb3_pkg::PIX_W-1:0]     s_tdata;
    logic [1:0]                    s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [bb3_pkg::PIX_W-1:0]     m_tdata;
    logic                          m_tlast;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bb3_pkg::CFG_W-1:0]     cfg_data;

    // blur predictor state
    logic [bb3_pkg::CFG_W-1:0] frm_width_q;
    logic [bb3_pkg::CFG_W-1:0] frm_height_q;
    logic [23:0]      upper_line [MAX_W];
    logic [23:0]      middle_line [MAX_W];
    logic [23:0]      win_cols [6];
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      emitted;

    pix_result_t blur_exp_q [$];
    int          err_count;
    int          pixels_taken;
    int          send_idle;
    int          recv_idle;
    int          hold_requests;
    int          holds_served;
    int          hold_left;

    // directed frames at 3x3: border pass-through, flush as black pixel,
    // ignored item after a full frame, frame start together with flush
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{8'hff, 8'h00, 8'hff, 1'b1, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{8'h00, 8'hff, 8'h00, 1'b0, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{8'h01, 8'h02, 8'h03, 1'b0, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{8'h80, 8'h40, 8'h20, 1'b0, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 1'b1, '{8'hff, 8'h00, 8'hff, 1'b0}},
        '{8'haa, 8'h55, 8'haa, 1'b0, 1'b1, 1'b1, '{8'h00, 8'hff, 8'h00, 1'b0}},
        '{8'hc8, 8'h64, 8'h32, 1'b0, 1'b0, 1'b1, '{8'h01, 8'h02, 8'h03, 1'b0}},
        '{8'h0a, 8'h14, 8'h1e, 1'b0, 1'b0, 1'b1, '{8'h80, 8'h40, 8'h20, 1'b0}},
        '{8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{8'h12, 8'h34, 8'h56, 1'b0, 1'b1, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1, '{8'hc8, 8'h64, 8'h32, 1'b0}},
        '{8'hff, 8'hff, 8'hff, 1'b0, 1'b1, 1'b1, '{8'h0a, 8'h14, 8'h1e, 1'b0}},
        '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1, '{8'hff, 8'hff, 8'hff, 1'b1}},
        '{8'h77, 8'h77, 8'h77, 1'b0, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{8'hff, 8'hff, 8'hff, 1'b1, 1'b1, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0}}
    };

    box_blur_3x3_stream i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // size register as the block uses it
    function automatic int unsigned size_in_use(input logic [bb3_pkg::CFG_W-1:0] v,
                                                input int hi);
        if (v < bb3_pkg::MIN_SIZE)
            return bb3_pkg::MIN_SIZE;
        if (v > hi)
            return hi;
        return 32'(v);
    endfunction

    function automatic bit frame_complete();
        return emitted >= size_in_use(frm_width_q, MAX_W) * size_in_use(frm_height_q, MAX_H);
    endfunction

    // advance the blur predictor by one accepted pixel
    function automatic void predict_blur(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input bit fs, input bit fl,
                                         output bit taken, output bit has_res,
                                         output pix_result_t res);
        int unsigned w, h, total, c, orow, ocol, sum;
        int          k, j;
        logic [23:0] px, up, mid, outpx;
        bit          interior;
        w = size_in_use(frm_width_q, MAX_W);
        h = size_in_use(frm_height_q, MAX_H);
        total = w * h;
        taken = 1'b0;
        has_res = 1'b0;
        res = '0;
        outpx = '0;
        orow = 0;
        ocol = 0;
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
            emitted = 0;
        end
        // whole frame given: item ignored
        if (emitted >= total)
            return;
        taken = 1'b1;
        px = fl ? 24'h0 : {r, g, b};
        c = (col_pos < MAX_W) ? col_pos : MAX_W - 1;
        up = upper_line[c];
        mid = middle_line[c];
        upper_line[c] = mid;
        middle_line[c] = px;

        // output position lags one line plus one pixel
        if (col_pos == 0)
        begin
            if (row_pos >= 2)
            begin
                has_res = 1'b1;
                orow = row_pos - 2;
                ocol = w - 1;
            end
        end
        else if (row_pos >= 1)
        begin
            has_res = 1'b1;
            orow = row_pos - 1;
            ocol = col_pos - 1;
        end

        if (has_res)
        begin
            interior = orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w
                       && col_pos != 0;
            for (k = 0; k < 3; k++)
            begin
                if (interior)
                begin
                    sum = 32'(up[8*k +: 8]) + 32'(mid[8*k +: 8]) + 32'(px[8*k +: 8]);
                    for (j = 0; j < 6; j++)
                        sum += 32'(win_cols[j][8*k +: 8]);
                    outpx[8*k +: 8] = 8'(sum / 9);
                end
                else
                begin
                    outpx[8*k +: 8] = win_cols[1][8*k +: 8];
                end
            end
        end

        win_cols[3] = win_cols[0];
        win_cols[4] = win_cols[1];
        win_cols[5] = win_cols[2];
        win_cols[0] = up;
        win_cols[1] = mid;
        win_cols[2] = px;

        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        else
        begin
            col_pos++;
        end

        if (has_res)
        begin
            res.red = outpx[23:16];
            res.green = outpx[15:8];
            res.blue = outpx[7:0];
            res.frame_end = (emitted + 1 == total);
            emitted++;
        end
    endfunction

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // one pixel transaction on the slave side
    task automatic send_item(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input bit fs, input bit fl, input bit use_typed,
                             input pix_result_t typed);
        bit          taken, has_res;
        pix_result_t res;
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, g, r};
        s_tuser <= {fl, fs};
        do
            @(posedge clk);
        while (!s_tready);
        predict_blur(r, g, b, fs, fl, taken, has_res, res);
        if (use_typed)
        begin
            has_res = 1'b1;
            res = typed;
        end
        if (has_res)
            blur_exp_q.push_back(res);
        if (taken)
            pixels_taken++;
    endtask

    task automatic send_pixel(input bit fs, input bit fl);
        send_item(rand_chan(), rand_chan(), rand_chan(), fs, fl, 1'b0, '0);
    endtask

    // register write transaction
    task automatic cfg_write(input bb3_pkg::cfg_reg_t idx,
                             input logic [bb3_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == bb3_pkg::REG_FRAME_WIDTH)
            frm_width_q = value;
        else
            frm_height_q = value;
    endtask

    task automatic set_size(input logic [bb3_pkg::CFG_W-1:0] w,
                            input logic [bb3_pkg::CFG_W-1:0] h);
        cfg_write(bb3_pkg::REG_FRAME_WIDTH, w);
        cfg_write(bb3_pkg::REG_FRAME_HEIGHT, h);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop offering, wait for every pending result and the pipeline tail
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (blur_exp_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    // one frame at the current size, cut short when broken
    task automatic send_frame(input bit broken);
        int unsigned n, stop, i;
        n = size_in_use(frm_width_q, MAX_W) * size_in_use(frm_height_q, MAX_H);
        stop = broken ? $urandom_range(1, n - 1) : n;
        for (i = 0; i < stop; i++)
        begin
            if (i == 0)
                send_pixel(1'b1, $urandom_range(9) == 0);
            else
                send_pixel(1'b0, $urandom_range(19) == 0);
        end
        if (!broken)
        begin
            while (!frame_complete())
                send_pixel(1'b0, 1'b1);
        end
        // trailing items without frame start
        repeat ($urandom_range(2))
            send_pixel(1'b0, 1'($urandom_range(1)));
    endtask

    // result checker
    always @(posedge clk)
    begin
        pix_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (blur_exp_q.size() == 0)
            begin
                report_mismatch("unexpected result", 32'(m_tdata), 32'd0);
            end
            else
            begin
                want = blur_exp_q.pop_front();
                if (m_tdata[7:0] !== want.red)
                    report_mismatch("red", 32'(m_tdata[7:0]), 32'(want.red));
                if (m_tdata[15:8] !== want.green)
                    report_mismatch("green", 32'(m_tdata[15:8]), 32'(want.green));
                if (m_tdata[23:16] !== want.blue)
                    report_mismatch("blue", 32'(m_tdata[23:16]), 32'(want.blue));
                if (m_tlast !== want.frame_end)
                    report_mismatch("frame_end", 32'(m_tlast), 32'(want.frame_end));
            end
        end
    end

    // receiver ready with random stalls and long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_requests != holds_served)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        int idle_run;
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("simulation failed");
        $finish;
    end

    // stimulus
    initial
    begin
        int                        i, ph, phase_start;
        bit                        held;
        logic [bb3_pkg::CFG_W-1:0] w_val, h_val;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = bb3_pkg::REG_FRAME_WIDTH;
        cfg_data = '0;
        err_count = 0;
        pixels_taken = 0;
        send_idle = 0;
        recv_idle = 0;
        hold_requests = 0;
        holds_served = 0;
        hold_left = 0;
        held = 1'b0;

        // predictor reset
        frm_width_q = bb3_pkg::FRAME_WIDTH_RST;
        frm_height_q = bb3_pkg::FRAME_HEIGHT_RST;
        for (i = 0; i < MAX_W; i++)
        begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        for (i = 0; i < 6; i++)
            win_cols[i] = '0;
        col_pos = 0;
        row_pos = 0;
        emitted = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table at the smallest frame
        set_size(11'd3, 11'd3);
        for (i = 0; i < DIR_ROWS; i++)
            send_item(dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue,
                      dir_rows[i].frame_start, dir_rows[i].flush,
                      dir_rows[i].checked, dir_rows[i].want);

        // random frames under three idling patterns
        for (ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 11 : (ph == 1) ? 50 : 0;
            recv_idle = (ph == 0) ? 50 : (ph == 1) ? 11 : 0;
            phase_start = pixels_taken;
            while (pixels_taken - phase_start < PHASE_PIXELS)
            begin
                w_val = ($urandom_range(9) == 0) ? 11'($urandom_range(2))
                                                 : 11'($urandom_range(3, 12));
                h_val = ($urandom_range(9) == 0) ? 11'($urandom_range(2))
                                                 : 11'($urandom_range(3, 7));
                wait_idle();
                set_size(w_val, h_val);
                repeat ($urandom_range(1, 3))
                begin
                    if (ph == 2 && !held)
                    begin
                        hold_requests++;
                        held = 1'b1;
                    end
                    send_frame($urandom_range(4) == 0);
                end
            end
        end

        // register extremes: zero width with the tallest height, first rows only
        wait_idle();
        set_size(11'd0, 11'd2047);
        for (i = 0; i < 60; i++)
            send_pixel(i == 0, 1'b0);

        // widest width with zero height, start of the first line
        wait_idle();
        set_size(11'd2047, 11'd0);
        for (i = 0; i < 40; i++)
            send_pixel(i == 0, 1'b0);

        // width shrinks mid-frame while the column is past the new width
        wait_idle();
        set_size(11'd7, 11'd5);
        for (i = 0; i < 20; i++)
            send_pixel(i == 0, 1'b0);
        wait_idle();
        cfg_write(bb3_pkg::REG_FRAME_WIDTH, 11'd5);
        @(negedge clk);
        cfg_valid <= 1'b0;
        while (!frame_complete())
            send_pixel(1'b0, 1'($urandom_range(1)));

        wait_idle();
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
